// ----- rtl/core/gpqm_pkg.sv -----
// ----------------------------------------------------------------------------
// gpqm_pkg
// Shared types, constants and the quarter-wave trig table for the mapper.
// ----------------------------------------------------------------------------
package gpqm_pkg;

  localparam int unsigned MAX_BPS = 8;
  localparam logic [63:0] PI_Q31  = 64'd6746518852;

  // register indexes on the config port
  localparam logic REG_MOD_KIND = 1'b0;
  localparam logic REG_BPS      = 1'b1;

  typedef enum logic {
    MOD_PSK = 1'b0,
    MOD_QAM = 1'b1
  } mod_kind_t;

  // one symbol request from the group sequencer
  typedef struct packed {
    logic [7:0] grp;       // raw Gray group, low bits
    logic       last_sym;  // final symbol of this byte
    logic       bad_cfg;   // bits per symbol out of range
  } sym_req_t;

  typedef struct packed {
    logic signed [15:0] i_val;
    logic signed [15:0] q_val;
    logic               err;
  } point_t;

  // {sin, cos} of r*pi/256 in units of 1/1024, r = 0..127
  typedef logic [21:0] trig_tab_t [128];

  localparam logic [63:0] SIN_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };
  localparam logic [63:0] COS_DIV [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  // Taylor series in Q31, evaluated at elaboration only
  function automatic trig_tab_t build_trig_tab();
    trig_tab_t          tab;
    logic [63:0]        th;
    logic [63:0]        th2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] ss;
    logic signed [63:0] cs;
    logic [63:0]        s_u;
    logic [63:0]        c_u;
    for (int r = 0; r < 128; r++) begin
      th  = (64'(r) * PI_Q31) >> 8;
      th2 = (th * th) >> 31;
      ts  = th;
      tc  = 64'd1 << 31;
      ss  = $signed(th);
      cs  = $signed(64'd1 << 31);
      for (int n = 0; n < 12; n++) begin
        ts = ((ts * th2) >> 31) / SIN_DIV[n];
        tc = ((tc * th2) >> 31) / COS_DIV[n];
        if ((n % 2) == 0) begin
          ss = ss - $signed(ts);
          cs = cs - $signed(tc);
        end else begin
          ss = ss + $signed(ts);
          cs = cs + $signed(tc);
        end
      end
      if (ss < 0) ss = '0;
      if (cs < 0) cs = '0;
      s_u = ($unsigned(ss) + (64'd1 << 20)) >> 21;
      c_u = ($unsigned(cs) + (64'd1 << 20)) >> 21;
      tab[r] = {s_u[10:0], c_u[10:0]};
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig_tab();

  // low-n-bits mask, n = 0..8
  function automatic logic [7:0] low_mask(input logic [3:0] n);
    logic [15:0] m;
    m = (16'd1 << n) - 16'd1;
    return m[7:0];
  endfunction

endpackage

// ----- rtl/core/gray_psk_qam_symbol_mapper.sv -----
// ----------------------------------------------------------------------------
// gray_psk_qam_symbol_mapper
// Gray-coded PSK / square-QAM mapper: bytes in, Q5.10 I/Q symbols out.
// ----------------------------------------------------------------------------
//  port group | dir | tdata (low bit up)              | tuser        | tlast
//  in_        | in  | data_byte[7:0]                  | -            | last_byte
//  out_       | out | in_phase[15:0], quadrature[15:0]| config_error | last_of_byte
//  cfg_       | in  | index 0 modulation_kind, 1 bits_per_symbol (write only)
//
//  One symbol per cycle while the output slot is free. A byte yields
//  floor((held + 8) / bits_per_symbol) symbols (1..8), set by the single
//  group-extraction path; an out-of-range bits_per_symbol gives one error symbol.
//  The next byte is taken in the cycle its predecessor's last symbol leaves.
//  Output register holds one symbol; out_tready reaches in_tready through the
//  slot-free term, so a stall holds the sequencer and, while a byte is in
//  progress, the input as well.
//  Synchronous active-low reset clears handshake state and held bits.
// ----------------------------------------------------------------------------
module gray_psk_qam_symbol_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] in_phase, [31:16] quadrature
  output logic        out_tuser,  // [0] config_error
  output logic        out_tlast,  // last_of_byte
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import gpqm_pkg::*;

  // configuration
  mod_kind_t  kind_r, kind_nxt;
  logic [3:0] bps_r,  bps_nxt;

  // output register
  logic        ovld_r, ovld_nxt;
  point_t      opt_r,  opt_nxt;
  logic        olast_r, olast_nxt;

  logic        slot_free;
  logic        req_valid;
  sym_req_t    req;
  point_t      pt;

  always_comb begin
    kind_nxt = kind_r;
    bps_nxt  = bps_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MOD_KIND: kind_nxt = mod_kind_t'(cfg_wdata[0]);
        default:      bps_nxt  = cfg_wdata;
      endcase
    end
  end

  assign slot_free = !ovld_r || out_tready;

  gpqm_group_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid),
    .byte_ready (in_tready),
    .byte_data  (in_tdata),
    .byte_last  (in_tlast),
    .cfg_we     (cfg_we),
    .bps        (bps_r),
    .slot_free  (slot_free),
    .req_valid  (req_valid),
    .req        (req)
  );

  gpqm_point_map u_map (
    .req  (req),
    .bps  (bps_r),
    .kind (kind_r),
    .pt   (pt)
  );

  always_comb begin
    ovld_nxt  = ovld_r;
    opt_nxt   = opt_r;
    olast_nxt = olast_r;
    if (req_valid) begin
      ovld_nxt  = 1'b1;
      opt_nxt   = pt;
      olast_nxt = req.last_sym;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= MOD_PSK;
      bps_r  <= 4'd2;
      ovld_r <= 1'b0;
    end else begin
      kind_r <= kind_nxt;
      bps_r  <= bps_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opt_r   <= opt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {opt_r.q_val, opt_r.i_val};
  assign out_tuser  = opt_r.err;
  assign out_tlast  = olast_r;

  // error symbols carry zero I/Q
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 32'd0))
    else $error("error symbol with non-zero I/Q");

  // an out-of-range setting always closes its byte in one symbol
  a_bad_last : assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid && req.bad_cfg) |-> req.last_sym)
    else $error("bad-setting symbol not marked last");

  // a symbol is only issued into a free output slot
  a_slot : assert property (@(posedge clk) disable iff (!rst_n)
    req_valid |-> slot_free)
    else $error("symbol issued into occupied output register");

endmodule

// ----- rtl/core/gpqm_group_seq.sv -----
// ----------------------------------------------------------------------------
// gpqm_group_seq
// Byte register and bit-group sequencer: one group per cycle unless stalled,
// MSB first, with leftover bits of a non-last byte carried into the next byte.
// ----------------------------------------------------------------------------
module gpqm_group_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [7:0]        byte_data,
  input  logic              byte_last,
  input  logic              cfg_we,
  input  logic [3:0]        bps,
  input  logic              slot_free,
  output logic              req_valid,
  output gpqm_pkg::sym_req_t req
);
  import gpqm_pkg::*;

  logic        busy_r,  busy_nxt;
  logic [15:0] word_r,  word_nxt;
  logic [3:0]  rem_r,   rem_nxt;
  logic        last_r,  last_nxt;
  logic [7:0]  acc_r,   acc_nxt;
  logic [2:0]  held_r,  held_nxt;

  logic        bad;
  logic        emit;
  logic [3:0]  rem_dn;
  logic        fin;
  logic        done;
  logic        keep;
  logic [15:0] shifted;
  logic [7:0]  acc_fwd;
  logic [2:0]  held_fwd;
  logic [7:0]  acc_src;
  logic [2:0]  held_src;
  logic        take;

  always_comb begin
    bad      = (bps == 4'd0) || (bps > 4'(MAX_BPS));
    emit     = busy_r && slot_free;
    rem_dn   = rem_r - bps;
    fin      = bad || (rem_dn < bps);
    done     = emit && fin;
    shifted  = word_r >> rem_dn;
    keep     = !last_r && !bad;
    acc_fwd  = keep ? (word_r[7:0] & low_mask(rem_dn)) : 8'd0;
    held_fwd = keep ? rem_dn[2:0] : 3'd0;
    acc_src  = done ? acc_fwd : acc_r;
    held_src = done ? held_fwd : held_r;

    byte_ready = !busy_r || done;
    take       = byte_valid && byte_ready;

    req_valid    = emit;
    req.grp      = shifted[7:0] & low_mask(bps);
    req.last_sym = fin;
    req.bad_cfg  = bad;

    busy_nxt = busy_r;
    word_nxt = word_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    acc_nxt  = acc_r;
    held_nxt = held_r;

    if (done) begin
      busy_nxt = 1'b0;
      acc_nxt  = acc_fwd;
      held_nxt = held_fwd;
    end else if (emit) begin
      rem_nxt = rem_dn;
    end

    if (take) begin
      busy_nxt = 1'b1;
      word_nxt = {acc_src, byte_data};
      rem_nxt  = {1'b0, held_src} + 4'd8;
      last_nxt = byte_last;
    end

    // a register write drops any partial group
    if (cfg_we) begin
      acc_nxt  = 8'd0;
      held_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      acc_r  <= 8'd0;
      held_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    rem_r  <= rem_nxt;
    last_r <= last_nxt;
  end

endmodule

// ----- rtl/core/gpqm_point_map.sv -----
// ----------------------------------------------------------------------------
// gpqm_point_map
// Inverse Gray decode and PSK / square-QAM point lookup, Q5.10 output.
// ----------------------------------------------------------------------------
module gpqm_point_map (
  input  gpqm_pkg::sym_req_t  req,
  input  logic [3:0]          bps,
  input  gpqm_pkg::mod_kind_t kind,
  output gpqm_pkg::point_t    pt
);
  import gpqm_pkg::*;

  logic [7:0]         j;
  logic [16:0]        k_wide;
  logic [8:0]         k;
  logic [21:0]        sc;
  logic [15:0]        s_x;
  logic [15:0]        c_x;
  logic [2:0]         half;
  logic [4:0]         lv;
  logic [7:0]         row;
  logic [7:0]         col;
  logic signed [6:0]  re;
  logic signed [6:0]  im;

  always_comb begin
    // inverse Gray: prefix XOR from the top bit down
    j[7] = req.grp[7];
    for (int b = 6; b >= 0; b--) begin
      j[b] = j[b+1] ^ req.grp[b];
    end
    j = j & low_mask(bps);

    // PSK angle index in units of pi/256
    k_wide = 17'({j, 1'b1}) << (4'd8 - bps);
    k      = k_wide[8:0];
    sc     = TRIG_TAB[k[6:0]];
    s_x    = {5'd0, sc[21:11]};
    c_x    = {5'd0, sc[10:0]};

    // QAM grid, snake layout
    half = bps[3:1];
    lv   = 5'((6'd1 << half) - 6'd1);
    row  = j >> half;
    col  = j & {3'd0, lv};
    re   = $signed({1'b0, col[4:0], 1'b0}) - $signed({2'b0, lv});
    if (!row[0]) re = -re;
    im   = $signed({2'b0, lv}) - $signed({1'b0, row[4:0], 1'b0});

    pt = '0;
    if (req.bad_cfg) begin
      pt.err = 1'b1;
    end else if (kind == MOD_PSK) begin
      unique case (k[8:7])
        2'd0: begin pt.i_val = c_x;      pt.q_val = s_x;      end
        2'd1: begin pt.i_val = -s_x;     pt.q_val = c_x;      end
        2'd2: begin pt.i_val = -c_x;     pt.q_val = -s_x;     end
        default: begin pt.i_val = s_x;   pt.q_val = -c_x;     end
      endcase
    end else if (bps[0]) begin
      pt.err = 1'b1;
    end else begin
      pt.i_val = 16'(re) <<< 10;
      pt.q_val = 16'(im) <<< 10;
    end
  end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gray PSK/QAM symbol mapper. A short table of
// corner bytes is followed by random bytes over many register settings, with
// random gaps on the byte input and random stalls on the symbol output. Every
// accepted byte is run through a local model of the mapper, and each symbol
// transfer is checked in order against it or a corner row's known values.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpqm_pkg::*;

  // pi in Q31, used for the angle of each PSK point
  localparam longint unsigned ANGLE_PI_Q31 = 64'd6746518852;
  // quiet cycles (no transfer on either side) before the run is abandoned
  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_PHASES = 12;

  // one predicted symbol, in output field order
  typedef struct packed {
    logic signed [15:0] i_v;
    logic signed [15:0] q_v;
    logic               err;
    logic               lst;
  } symbol_t;

  // corner table: optional register rewrite, then one byte; where known is set
  // every symbol of that byte must carry the I/Q/error values given
  typedef struct packed {
    logic               wr;
    mod_kind_t          kind;
    logic [3:0]         bps;
    logic [7:0]         data;
    logic               last;
    logic               known;
    logic signed [15:0] ki;
    logic signed [15:0] kq;
    logic               kerr;
  } corner_row_t;

  localparam corner_row_t CORNER_BYTES [25] = '{
    // reset settings (PSK, 2 bits): all-zero and all-one groups
    '{1'b0, MOD_PSK, 4'd2,  8'h00, 1'b0, 1'b1,  16'sd724,   16'sd724,  1'b0},
    '{1'b0, MOD_PSK, 4'd2,  8'hFF, 1'b0, 1'b1, -16'sd724,  -16'sd724,  1'b0},
    '{1'b0, MOD_PSK, 4'd2,  8'hA5, 1'b1, 1'b0,  16'sd0,     16'sd0,    1'b0},
    // one bit per symbol: eight symbols per byte
    '{1'b1, MOD_PSK, 4'd1,  8'h00, 1'b0, 1'b1,  16'sd0,     16'sd1024, 1'b0},
    '{1'b0, MOD_PSK, 4'd1,  8'hFF, 1'b0, 1'b1,  16'sd0,    -16'sd1024, 1'b0},
    // three bits: leftovers carried across bytes, then dropped after last
    '{1'b1, MOD_PSK, 4'd3,  8'h5A, 1'b0, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b0, MOD_PSK, 4'd3,  8'hC3, 1'b0, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b0, MOD_PSK, 4'd3,  8'h3C, 1'b1, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b0, MOD_PSK, 4'd3,  8'h81, 1'b0, 1'b0,  16'sd0,     16'sd0,    1'b0},
    // widest PSK
    '{1'b1, MOD_PSK, 4'd8,  8'h00, 1'b0, 1'b1,  16'sd1024,  16'sd13,   1'b0},
    '{1'b0, MOD_PSK, 4'd8,  8'hFF, 1'b1, 1'b0,  16'sd0,     16'sd0,    1'b0},
    // widest QAM (an outer corner, then an inner point), then narrower QAM sizes
    '{1'b1, MOD_QAM, 4'd8,  8'h00, 1'b0, 1'b1,  16'sd15360, 16'sd15360, 1'b0},
    '{1'b0, MOD_QAM, 4'd8,  8'hFF, 1'b0, 1'b1, -16'sd5120, -16'sd5120, 1'b0},
    '{1'b1, MOD_QAM, 4'd2,  8'h1B, 1'b0, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b1, MOD_QAM, 4'd6,  8'h96, 1'b0, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b0, MOD_QAM, 4'd6,  8'h69, 1'b1, 1'b0,  16'sd0,     16'sd0,    1'b0},
    // odd bits with QAM: error on every symbol
    '{1'b1, MOD_QAM, 4'd3,  8'hFF, 1'b0, 1'b1,  16'sd0,     16'sd0,    1'b1},
    '{1'b0, MOD_QAM, 4'd3,  8'h00, 1'b1, 1'b1,  16'sd0,     16'sd0,    1'b1},
    // bits per symbol out of range: one error symbol per byte
    '{1'b1, MOD_PSK, 4'd0,  8'h7E, 1'b0, 1'b1,  16'sd0,     16'sd0,    1'b1},
    '{1'b1, MOD_QAM, 4'd15, 8'h80, 1'b1, 1'b1,  16'sd0,     16'sd0,    1'b1},
    // a rewrite between bytes throws away the held bits
    '{1'b1, MOD_PSK, 4'd5,  8'hF0, 1'b0, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b1, MOD_PSK, 4'd5,  8'h0F, 1'b0, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b0, MOD_PSK, 4'd5,  8'hE7, 1'b1, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b1, MOD_QAM, 4'd4,  8'hD2, 1'b0, 1'b0,  16'sd0,     16'sd0,    1'b0},
    '{1'b1, MOD_PSK, 4'd9,  8'h01, 1'b0, 1'b1,  16'sd0,     16'sd0,    1'b1}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [7:0] data_byte
  logic        in_tlast   = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [15:0] in_phase, [31:16] quadrature
  logic        out_tuser;         // [0] config_error
  logic        out_tlast;         // last_of_byte
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = REG_MOD_KIND;
  logic [3:0]  cfg_wdata  = '0;

  // model copy of registers and bit gatherer
  mod_kind_t   kind_now  = MOD_PSK;
  logic [3:0]  bps_now   = 4'd2;
  logic [7:0]  held_bits = '0;
  int          held_cnt  = 0;

  symbol_t     symbols_due[$];   // predicted symbols not yet transferred
  int unsigned n_fail     = 0;
  logic        burst_mode = 1'b0; // no gaps or stalls on either side
  int          quiet_cnt  = 0;
  int          stall_left = 0;

  gray_psk_qam_symbol_mapper u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short idles, the odd long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sin/cos of r*pi/256 (r = 0..127) by Taylor series in Q31, rounded to 1/1024
  function automatic void quarter_sin_cos(input int unsigned r, output int sn,
                                          output int cs);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned ts;
    longint unsigned tc;
    longint          s_acc;
    longint          c_acc;
    th    = (64'(r) * ANGLE_PI_Q31) >> 8;
    th2   = (th * th) >> 31;
    ts    = th;
    tc    = 64'd1 << 31;
    s_acc = $signed(th);
    c_acc = $signed(64'd1 << 31);
    for (int n = 1; n <= 12; n++) begin
      ts = ((ts * th2) >> 31) / 64'((2 * n) * (2 * n + 1));
      tc = ((tc * th2) >> 31) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        s_acc = s_acc - $signed(ts);
        c_acc = c_acc - $signed(tc);
      end else begin
        s_acc = s_acc + $signed(ts);
        c_acc = c_acc + $signed(tc);
      end
    end
    if (s_acc < 0) s_acc = 0;
    if (c_acc < 0) c_acc = 0;
    sn = int'((64'(s_acc) + (64'd1 << 20)) >> 21);
    cs = int'((64'(c_acc) + (64'd1 << 20)) >> 21);
  endfunction

  // one Gray group to a constellation point under the current settings
  function automatic void map_group(input logic [7:0] grp, output logic signed [15:0] iv,
                                    output logic signed [15:0] qv, output logic err);
    logic [7:0] j;
    int         ang;
    int         sn;
    int         cs;
    int         half;
    int         lv;
    int         row;
    int         col;
    int         re;
    j   = grp ^ (grp >> 1);
    j   = j ^ (j >> 2);
    j   = j ^ (j >> 4);
    j   = j & 8'((9'd1 << bps_now) - 9'd1);
    iv  = '0;
    qv  = '0;
    err = 1'b0;
    if (kind_now == MOD_PSK) begin
      // angle in units of pi/256, offset by half a step
      ang = ((2 * int'(j) + 1) << (8 - bps_now)) & 511;
      quarter_sin_cos(ang & 127, sn, cs);
      case (ang >> 7)
        0: begin
          iv = 16'(cs);
          qv = 16'(sn);
        end
        1: begin
          iv = 16'(-sn);
          qv = 16'(cs);
        end
        2: begin
          iv = 16'(-cs);
          qv = 16'(-sn);
        end
        default: begin
          iv = 16'(sn);
          qv = 16'(-cs);
        end
      endcase
    end else if (bps_now[0]) begin
      err = 1'b1;
    end else begin
      // snake layout: odd rows run left to right, even rows mirrored
      half = bps_now / 2;
      lv   = (1 << half) - 1;
      row  = int'(j) >> half;
      col  = int'(j) & lv;
      re   = 2 * col - lv;
      if (row % 2 == 0) re = -re;
      iv = 16'(re * 1024);
      qv = 16'((lv - 2 * row) * 1024);
    end
  endfunction

  // symbols caused by one accepted byte; advances the bit gatherer
  function automatic void predict_byte(input logic [7:0] d, input logic l,
                                       output symbol_t syms[$]);
    logic [15:0] joined;
    int          avail;
    symbol_t     s;
    syms = {};
    if (bps_now < 1 || bps_now > MAX_BPS) begin
      held_bits = '0;
      held_cnt  = 0;
      s = '{16'sd0, 16'sd0, 1'b1, 1'b1};
      syms.push_back(s);
      return;
    end
    joined = {held_bits, d};
    avail  = held_cnt + 8;
    while (avail >= int'(bps_now) && syms.size() < 8) begin
      avail = avail - int'(bps_now);
      s.lst = 1'b0;
      map_group(8'((joined >> avail) & ((16'd1 << bps_now) - 16'd1)),
                s.i_v, s.q_v, s.err);
      syms.push_back(s);
    end
    if (avail > 7) avail = 7;
    held_bits = 8'(joined & ((16'd1 << avail) - 16'd1));
    held_cnt  = avail;
    if (l) begin
      held_bits = '0;
      held_cnt  = 0;
    end
    syms[syms.size() - 1].lst = 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      n_fail++;
    end
  endfunction

  // hold off input until every predicted symbol has been transferred
  task automatic settle();
    in_tvalid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers, one write each; any write clears the held bits
  task automatic write_cfg(input mod_kind_t kind, input logic [3:0] bps);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MOD_KIND;
    cfg_wdata <= {3'b000, kind};
    @(posedge clk);
    cfg_index <= REG_BPS;
    cfg_wdata <= bps;
    @(posedge clk);
    cfg_we    <= 1'b0;
    kind_now  = kind;
    bps_now   = bps;
    held_bits = '0;
    held_cnt  = 0;
  endtask

  // offer one byte, wait for its transfer, then queue its symbols
  task automatic send_byte(input logic [7:0] d, input logic l, input logic known,
                           input logic signed [15:0] ki, input logic signed [15:0] kq,
                           input logic kerr);
    symbol_t fresh[$];
    int      gap;
    gap = (burst_mode || $urandom_range(0, 1)) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_byte(d, l, fresh);
    if (known) begin
      foreach (fresh[k]) begin
        fresh[k].i_v = ki;
        fresh[k].q_v = kq;
        fresh[k].err = kerr;
      end
    end
    foreach (fresh[k]) symbols_due.push_back(fresh[k]);
  endtask

  // symbol side back-pressure: random stalls unless in a burst stretch
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= idle_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // every symbol transfer is matched against the oldest prediction
  always @(posedge clk) begin : symbol_check
    symbol_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (symbols_due.size() == 0) begin
        $error("symbol transfer with none predicted: I=%0d Q=%0d",
               $signed(out_tdata[15:0]), $signed(out_tdata[31:16]));
        n_fail++;
      end else begin
        want = symbols_due.pop_front();
        check_field("in_phase", want.i_v, out_tdata[15:0]);
        check_field("quadrature", want.q_v, out_tdata[31:16]);
        check_field("config_error", {15'b0, want.err}, {15'b0, out_tuser});
        check_field("last_of_byte", {15'b0, want.lst}, {15'b0, out_tlast});
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin : stimulus
    mod_kind_t  kind;
    logic [3:0] bps;
    int         n_bytes;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner bytes first, starting from the reset settings
    foreach (CORNER_BYTES[r]) begin
      if (CORNER_BYTES[r].wr) begin
        settle();
        write_cfg(CORNER_BYTES[r].kind, CORNER_BYTES[r].bps);
      end
      send_byte(CORNER_BYTES[r].data, CORNER_BYTES[r].last, CORNER_BYTES[r].known,
                CORNER_BYTES[r].ki, CORNER_BYTES[r].kq, CORNER_BYTES[r].kerr);
    end

    // random phases: new settings each time, mostly in range
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      kind = mod_kind_t'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        bps = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
      end else begin
        bps = 4'($urandom_range(1, 8));
      end
      write_cfg(kind, bps);
      burst_mode = ($urandom_range(0, 3) == 0);
      n_bytes = $urandom_range(34, 42);
      repeat (n_bytes) begin
        // now and then let the output drain completely mid-stream
        if ($urandom_range(0, 39) == 0) settle();
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                  1'b0, 16'sd0, 16'sd0, 1'b0);
      end
    end

    burst_mode = 1'b0;
    settle();
    repeat (16) @(posedge clk);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gpqm_pkg.sv
rtl/core/gpqm_group_seq.sv
rtl/core/gpqm_point_map.sv
rtl/core/gray_psk_qam_symbol_mapper.sv
verif/tb.sv
